>>> rtl/decaying_priority_scheduler_unit_assert.svh
// Assertion macros shared by the scheduler's checker.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef DECAYING_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define DECAYING_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dps_pkg.sv
// Package for the decaying priority scheduler: sizes, status codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package dps_pkg;

  // Process table geometry.
  localparam int MAX_PROCS = 8;
  localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  // Field widths.
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 13;
  localparam int TICK_W   = 8;
  localparam int TIME_W   = 16;
  localparam int DECAY_W  = 4;
  localparam int STATUS_W = 2;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 4'd3;
  localparam logic signed [PRIO_W:0] PRIO_MIN = -14'sd4096;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RAN    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd3;

  // Input function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_in;
    logic scan_clr;
    logic scan_step;
    logic commit;
  } dps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } dps_stat_t;

endpackage

`default_nettype wire

>>> rtl/dps_ctrl.sv
// Controller state machine of the scheduler: handshakes and scan sequencing.
// Depends on dps_pkg for the command and status structs.
`default_nettype none

module dps_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              in_func,
  output logic             out_valid,
  input  wire              out_ready,
  output dps_pkg::dps_cmd_t cmd,
  input  dps_pkg::dps_stat_t stat
);
  import dps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in   = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = (in_func == FUNC_TICK) ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.commit | (out_valid_r & ~out_ready);
  end

  // State and registered output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/dps_datapath.sv
// Datapath of the scheduler: process table, slot scan, tick update and the
// result register. Depends on dps_pkg; driven by dps_ctrl commands.
`default_nettype none

module dps_datapath (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  dps_pkg::dps_cmd_t                   cmd,
  output dps_pkg::dps_stat_t                  stat,
  input  wire                                 cfg_we,
  input  wire  [dps_pkg::DECAY_W-1:0]         cfg_data,
  input  wire                                 in_func,
  input  wire  [dps_pkg::ID_W-1:0]            in_process_id,
  input  wire  [dps_pkg::TICK_W-1:0]          in_start_priority,
  input  wire  [dps_pkg::TICK_W-1:0]          in_need_ticks,
  output logic [dps_pkg::STATUS_W-1:0]        out_status,
  output logic [dps_pkg::ID_W-1:0]            out_running_id,
  output logic signed [dps_pkg::PRIO_W-1:0]   out_running_priority,
  output logic [dps_pkg::TICK_W-1:0]          out_used_ticks,
  output logic                                out_preempted,
  output logic                                out_finished,
  output logic [dps_pkg::TIME_W-1:0]          out_finish_time
);
  import dps_pkg::*;

  // Captured input beat.
  logic              func_r;
  logic [ID_W-1:0]   pid_r;
  logic [TICK_W-1:0] sprio_r;
  logic [TICK_W-1:0] need_r;

  logic [DECAY_W-1:0] decay_r;

  // Process table.
  logic [MAX_PROCS-1:0]     slot_valid_r;
  logic [ID_W-1:0]          slot_id_r   [MAX_PROCS];
  logic signed [PRIO_W-1:0] slot_prio_r [MAX_PROCS];
  logic [TICK_W-1:0]        slot_rem_r  [MAX_PROCS];
  logic [TICK_W-1:0]        slot_used_r [MAX_PROCS];

  logic              run_valid_r;
  logic [SLOT_W-1:0] run_slot_r;
  logic [TIME_W-1:0] elapsed_r;

  // Scan registers: best candidate and running process snapshot.
  logic [SLOT_W-1:0]        idx_r;
  logic                     best_v_r;
  logic [SLOT_W-1:0]        best_slot_r;
  logic signed [PRIO_W-1:0] best_prio_r;
  logic [ID_W-1:0]          best_id_r;
  logic [TICK_W-1:0]        best_rem_r;
  logic [TICK_W-1:0]        best_used_r;
  logic                     hit_r;
  logic signed [PRIO_W-1:0] run_prio_r;
  logic [ID_W-1:0]          run_id_r;
  logic [TICK_W-1:0]        run_rem_r;
  logic [TICK_W-1:0]        run_used_r;

  // Free slot search and tick arithmetic.
  logic                     free_found;
  logic [SLOT_W-1:0]        free_slot;
  logic                     cur_v;
  logic signed [PRIO_W-1:0] cur_prio;
  logic                     run_ok;
  logic                     preempt;
  logic                     use_run;
  logic                     sel_v;
  logic [SLOT_W-1:0]        sel_slot;
  logic signed [PRIO_W-1:0] sel_prio;
  logic [ID_W-1:0]          sel_id;
  logic [TICK_W-1:0]        sel_rem;
  logic [TICK_W-1:0]        sel_used;
  logic signed [PRIO_W:0]   prio_diff;
  logic signed [PRIO_W-1:0] new_prio;
  logic [TICK_W-1:0]        new_rem;
  logic [TICK_W-1:0]        new_used;
  logic [TIME_W-1:0]        new_elapsed;
  logic                     fin;

  // Lowest free slot for a load.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign cur_v          = slot_valid_r[idx_r];
  assign cur_prio       = slot_prio_r[idx_r];
  assign stat.scan_last = (idx_r == SLOT_W'(MAX_PROCS - 1));

  // Selection: the running process keeps the processor unless outranked.
  // The table maximum exceeds its priority exactly when another slot does.
  always_comb begin
    run_ok   = run_valid_r & hit_r;
    preempt  = run_ok & best_v_r & (best_prio_r > run_prio_r);
    use_run  = run_ok & ~preempt;
    sel_v    = use_run | best_v_r;
    sel_slot = use_run ? run_slot_r : best_slot_r;
    sel_prio = use_run ? run_prio_r : best_prio_r;
    sel_id   = use_run ? run_id_r   : best_id_r;
    sel_rem  = use_run ? run_rem_r  : best_rem_r;
    sel_used = use_run ? run_used_r : best_used_r;
  end

  // One tick of aging with saturation.
  always_comb begin
    prio_diff   = {sel_prio[PRIO_W-1], sel_prio}
                - $signed({{(PRIO_W + 1 - DECAY_W){1'b0}}, decay_r});
    new_prio    = (prio_diff < PRIO_MIN) ? PRIO_W'(PRIO_MIN) : prio_diff[PRIO_W-1:0];
    new_rem     = (sel_rem != '0) ? sel_rem - 1'b1 : '0;
    new_used    = (sel_used == '1) ? sel_used : sel_used + 1'b1;
    new_elapsed = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
    fin         = (new_rem == '0);
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      func_r  <= in_func;
      pid_r   <= in_process_id;
      sprio_r <= in_start_priority;
      need_r  <= in_need_ticks;
    end
  end

  // Decay register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
    end else if (cfg_we) begin
      decay_r <= cfg_data;
    end
  end

  // Slot scan: one table slot per cycle through one comparator.
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      idx_r    <= '0;
      best_v_r <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (cur_v && (!best_v_r || cur_prio > best_prio_r)) begin
        best_v_r    <= 1'b1;
        best_slot_r <= idx_r;
        best_prio_r <= cur_prio;
        best_id_r   <= slot_id_r[idx_r];
        best_rem_r  <= slot_rem_r[idx_r];
        best_used_r <= slot_used_r[idx_r];
      end
      if (cur_v && idx_r == run_slot_r) begin
        hit_r      <= 1'b1;
        run_prio_r <= cur_prio;
        run_id_r   <= slot_id_r[idx_r];
        run_rem_r  <= slot_rem_r[idx_r];
        run_used_r <= slot_used_r[idx_r];
      end
    end
  end

  // Control state of the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      run_valid_r  <= 1'b0;
      run_slot_r   <= '0;
      elapsed_r    <= '0;
    end else if (cmd.commit) begin
      if (func_r == FUNC_LOAD) begin
        if (free_found) begin
          slot_valid_r[free_slot] <= 1'b1;
        end
      end else if (sel_v) begin
        elapsed_r <= new_elapsed;
        if (fin) begin
          slot_valid_r[sel_slot] <= 1'b0;
          run_valid_r            <= 1'b0;
        end else begin
          run_valid_r <= 1'b1;
          run_slot_r  <= sel_slot;
        end
      end else begin
        run_valid_r <= 1'b0;
      end
    end
  end

  // Table payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (func_r == FUNC_LOAD) begin
        if (free_found) begin
          slot_id_r[free_slot]   <= pid_r;
          slot_prio_r[free_slot] <= $signed({{(PRIO_W - TICK_W){1'b0}}, sprio_r});
          slot_rem_r[free_slot]  <= need_r;
          slot_used_r[free_slot] <= '0;
        end
      end else if (sel_v) begin
        slot_prio_r[sel_slot] <= new_prio;
        slot_rem_r[sel_slot]  <= new_rem;
        slot_used_r[sel_slot] <= new_used;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_running_id       <= '0;
      out_running_priority <= '0;
      out_used_ticks       <= '0;
      out_preempted        <= 1'b0;
      out_finished         <= 1'b0;
      out_finish_time      <= '0;
      if (func_r == FUNC_LOAD) begin
        out_status <= free_found ? ST_LOADED : ST_FULL;
      end else if (sel_v) begin
        out_status           <= ST_RAN;
        out_running_id       <= sel_id;
        out_running_priority <= new_prio;
        out_used_ticks       <= new_used;
        out_preempted        <= preempt;
        out_finished         <= fin;
        out_finish_time      <= fin ? new_elapsed : '0;
      end else begin
        out_status <= ST_IDLE;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/decaying_priority_scheduler_unit.sv
// A load beat goes from the capture register through the commit state into the
// result register; a tick beat first scans the table in the scan state. The slot
// scan visits one table slot per cycle through one comparator. A new beat is taken
// only after the last one commits; the commit waits while the result register is full.
// Reset (rst_n low, synchronous): table empty, no running process, elapsed
// count zero, decay 3. No clearing pass; the block is ready right after reset.
`default_nettype none

module decaying_priority_scheduler_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [dps_pkg::DECAY_W-1:0]         cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_func,
  input  wire  [dps_pkg::ID_W-1:0]            in_process_id,
  input  wire  [dps_pkg::TICK_W-1:0]          in_start_priority,
  input  wire  [dps_pkg::TICK_W-1:0]          in_need_ticks,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [dps_pkg::STATUS_W-1:0]        out_status,
  output logic [dps_pkg::ID_W-1:0]            out_running_id,
  output logic signed [dps_pkg::PRIO_W-1:0]   out_running_priority,
  output logic [dps_pkg::TICK_W-1:0]          out_used_ticks,
  output logic                                out_preempted,
  output logic                                out_finished,
  output logic [dps_pkg::TIME_W-1:0]          out_finish_time
);
  import dps_pkg::*;

  dps_cmd_t  cmd;
  dps_stat_t stat;
  logic      cfg_we;

  // The decay register accepts a write beat in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  dps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  dps_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .in_func              (in_func),
    .in_process_id        (in_process_id),
    .in_start_priority    (in_start_priority),
    .in_need_ticks        (in_need_ticks),
    .out_status           (out_status),
    .out_running_id       (out_running_id),
    .out_running_priority (out_running_priority),
    .out_used_ticks       (out_used_ticks),
    .out_preempted        (out_preempted),
    .out_finished         (out_finished),
    .out_finish_time      (out_finish_time)
  );

endmodule

`default_nettype wire

>>> rtl/dps_checker.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on dps_pkg and the assertion macros header.
`default_nettype none

`include "decaying_priority_scheduler_unit_assert.svh"

module dps_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_ready,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [dps_pkg::STATUS_W-1:0]      out_status,
  input wire [dps_pkg::ID_W-1:0]          out_running_id,
  input wire [dps_pkg::TICK_W-1:0]        out_used_ticks,
  input wire                              out_preempted,
  input wire                              out_finished,
  input wire [dps_pkg::TIME_W-1:0]        out_finish_time
);
  import dps_pkg::*;

  // A stalled result beat stays valid and keeps its status.
  `DPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `DPS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_status), "status changed")

  // One item is in work at a time: the input closes after each beat.
  `DPS_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "second beat taken")

  // A finish is only reported on a tick that ran, and at a nonzero time.
  `DPS_ASSERT_SAME(a_finish, clk, rst_n, out_valid && out_finished, out_status == ST_RAN && out_finish_time != '0, "bad finish")

  // Results that ran nothing carry zero fields.
  `DPS_ASSERT_SAME(a_zero, clk, rst_n, out_valid && out_status != ST_RAN, out_running_id == '0 && out_used_ticks == '0 && !out_preempted && !out_finished, "nonzero fields")

endmodule

bind decaying_priority_scheduler_unit dps_checker u_dps_checker (.*);

`default_nettype wire

>>> tb/sv/tb_decaying_priority_scheduler_unit.sv
// Self-checking testbench for decaying_priority_scheduler_unit: valid/ready
// traffic with random idling, checked against a built-in scheduler predictor.
// Depends on dps_pkg and the RTL of the scheduler only.
`timescale 1ns / 1ps

module tb_decaying_priority_scheduler_unit;
  import dps_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;

  // One input beat as the sender holds it.
  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   pid;
    logic [TICK_W-1:0] prio;
    logic [TICK_W-1:0] need;
  } beat_t;

  // One result beat as the scheduler should report it.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [ID_W-1:0]         rid;
    logic signed [PRIO_W-1:0] prio;
    logic [TICK_W-1:0]       used;
    logic                    preempted;
    logic                    finished;
    logic [TIME_W-1:0]       ftime;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DECAY_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [ID_W-1:0] in_process_id = '0;
  logic [TICK_W-1:0] in_start_priority = '0;
  logic [TICK_W-1:0] in_need_ticks = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0] out_running_id;
  logic signed [PRIO_W-1:0] out_running_priority;
  logic [TICK_W-1:0] out_used_ticks;
  logic out_preempted;
  logic out_finished;
  logic [TIME_W-1:0] out_finish_time;

  // Beats waiting to be driven and results still owed by the block.
  beat_t    pending_beats[$];
  outcome_t outcome_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Predictor copy of the process table and scheduler state.
  logic            tbl_valid[MAX_PROCS];
  logic [ID_W-1:0] tbl_id[MAX_PROCS];
  int              tbl_prio[MAX_PROCS];
  int              tbl_left[MAX_PROCS];
  int              tbl_used[MAX_PROCS];
  logic            cpu_busy = 1'b0;
  int              cpu_slot = 0;
  int              run_clock = 0;
  int              decay_cfg = DECAY_RESET;

  decaying_priority_scheduler_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_process_id        (in_process_id),
    .in_start_priority    (in_start_priority),
    .in_need_ticks        (in_need_ticks),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_running_id       (out_running_id),
    .out_running_priority (out_running_priority),
    .out_used_ticks       (out_used_ticks),
    .out_preempted        (out_preempted),
    .out_finished         (out_finished),
    .out_finish_time      (out_finish_time)
  );

  always #10 clk = ~clk;

  // Applies one accepted beat to the table and returns the result it owes.
  function automatic outcome_t predict_schedule(beat_t b);
    outcome_t o;
    int free_slot;
    int sel;
    int p;
    logic outranked;
    o = '0;
    free_slot = -1;
    sel = -1;
    outranked = 1'b0;
    if (b.func == FUNC_LOAD) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        if (!tbl_valid[i] && free_slot < 0) free_slot = i;
      end
      if (free_slot < 0) begin
        o.status = ST_FULL;
      end else begin
        tbl_valid[free_slot] = 1'b1;
        tbl_id[free_slot]    = b.pid;
        tbl_prio[free_slot]  = int'(b.prio);
        tbl_left[free_slot]  = int'(b.need);
        tbl_used[free_slot]  = 0;
        o.status = ST_LOADED;
      end
      return o;
    end
    // The current runner keeps the processor unless someone strictly outranks it.
    if (cpu_busy && tbl_valid[cpu_slot]) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        if (i != cpu_slot && tbl_valid[i] && tbl_prio[i] > tbl_prio[cpu_slot]) outranked = 1'b1;
      end
      if (outranked) begin
        cpu_busy = 1'b0;
        o.preempted = 1'b1;
      end else begin
        sel = cpu_slot;
      end
    end else begin
      cpu_busy = 1'b0;
    end
    // Highest priority wins; ties stay with the lowest slot.
    if (sel < 0) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        if (tbl_valid[i] && (sel < 0 || tbl_prio[i] > tbl_prio[sel])) sel = i;
      end
    end
    if (sel < 0) begin
      o = '0;
      o.status = ST_IDLE;
      return o;
    end
    p = tbl_prio[sel] - decay_cfg;
    if (p < int'(PRIO_MIN)) p = int'(PRIO_MIN);
    tbl_prio[sel] = p;
    if (tbl_left[sel] > 0) tbl_left[sel]--;
    if (tbl_used[sel] < 255) tbl_used[sel]++;
    if (run_clock < 65535) run_clock++;
    if (tbl_left[sel] == 0) begin
      o.finished = 1'b1;
      o.ftime = run_clock[TIME_W-1:0];
      tbl_valid[sel] = 1'b0;
      cpu_busy = 1'b0;
    end else begin
      cpu_busy = 1'b1;
      cpu_slot = sel;
    end
    o.status = ST_RAN;
    o.rid = tbl_id[sel];
    o.prio = p[PRIO_W-1:0];
    o.used = tbl_used[sel][TICK_W-1:0];
    return o;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic push_load(int pid, int prio, int need);
    pending_beats.insert(pending_beats.size(),
                         beat_t'{FUNC_LOAD, pid[ID_W-1:0], prio[TICK_W-1:0],
                                 need[TICK_W-1:0]});
  endtask

  // Tick beats carry random content in the fields the block ignores.
  task automatic push_tick();
    pending_beats.insert(pending_beats.size(),
                         beat_t'{FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom)});
  endtask

  // Mostly short jobs so the table turns over; some zero, some full range.
  function automatic int pick_need();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 70) return $urandom_range(1, 5);
    if (r < 90) return $urandom_range(6, 30);
    return $urandom_range(0, 255);
  endfunction

  task automatic queue_directed();
    push_tick();                 // idle tick on an empty table
    push_load(8'hFF, 255, 0);    // zero need runs once and finishes
    push_load(8'h00, 0, 255);
    push_tick();
    push_tick();
    push_load(8'hA5, 10, 1);
    push_load(8'h5A, 200, 2);
    push_load(8'h33, 200, 3);    // ties with the slot before it
    push_load(8'h80, 1, 128);
    push_load(8'h01, 2, 64);
    push_load(8'h7F, 128, 32);
    push_load(8'hFE, 201, 2);    // table is now full
    push_load(8'h55, 99, 7);     // rejected
    repeat (5) push_tick();      // preemptions and tie breaking
  endtask

  // Bursts of loads and ticks with random content, plus the odd stray beat.
  task automatic queue_random(int count);
    int made;
    int mode;
    int len;
    made = 0;
    while (made < count) begin
      mode = $urandom_range(0, 99);
      if (mode < 35) begin
        len = $urandom_range(1, 6);
        repeat (len) push_load($urandom_range(0, 255), $urandom_range(0, 255), pick_need());
      end else if (mode < 90) begin
        len = $urandom_range(1, 20);
        repeat (len) push_tick();
      end else begin
        len = 1;
        pending_beats.insert(pending_beats.size(), beat_t'($urandom));
      end
      made += len;
    end
  endtask

  // Waits until every driven beat has been answered, then lets the block settle.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_decay(int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[DECAY_W-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    decay_cfg = value & 4'hF;
    cfg_valid <= 1'b0;
  endtask

  // Input driver: predicts each accepted beat and presents the next one.
  always @(posedge clk) begin : drive_beats
    beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        outcome_q.insert(outcome_q.size(),
                         predict_schedule(beat_t'{in_func, in_process_id,
                                                  in_start_priority, in_need_ticks}));
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          in_valid          <= 1'b1;
          in_func           <= nxt.func;
          in_process_id     <= nxt.pid;
          in_start_priority <= nxt.prio;
          in_need_ticks     <= nxt.need;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted beat with the oldest prediction.
  always @(posedge clk) begin : watch_results
    outcome_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, actual status %0d",
                   $time, out_status);
        end else begin
          want = outcome_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("running_id", want.rid, out_running_id);
          check_field("running_priority", want.prio, out_running_priority);
          check_field("used_ticks", want.used, out_used_ticks);
          check_field("preempted", want.preempted, out_preempted);
          check_field("finished", want.finished, out_finished);
          check_field("finish_time", want.ftime, out_finish_time);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequence of phases: each one its own decay setting and idling pattern.
  initial begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_prio[i] = 0;
      tbl_left[i] = 0;
      tbl_used[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset decay, no idling on either side.
    queue_directed();
    queue_random(400);
    wait_drained();

    // Largest decay, sender idles.
    write_decay(15);
    send_idle_pct = 53;
    recv_stall_pct = 0;
    queue_random(430);
    wait_drained();

    // No decay, receiver stalls.
    write_decay(0);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    queue_random(430);
    wait_drained();

    // Some middle decay, both sides idle.
    write_decay($urandom_range(1, 14));
    send_idle_pct = 22;
    recv_stall_pct = 22;
    queue_random(430);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
